// ===== rtl/core/udp_feed_sequence_monitor_unit_defines.svh =====
// ============================================================================
// UDP feed sequence monitor assertion macros
// Shared property shorthands. Each expects aclk and aresetn in scope.
// ============================================================================
`ifndef UDP_FEED_SEQUENCE_MONITOR_UNIT_DEFINES_SVH
`define UDP_FEED_SEQUENCE_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UFSM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ufsm: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define UFSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ufsm: property violated");

`endif

// ===== rtl/core/ufsm_pkg.sv =====
// ============================================================================
// UDP feed sequence monitor package
// Shared types, word layouts and protocol constants.
// ============================================================================
package ufsm_pkg;

    localparam int InDataW  = 72;
    localparam int OutDataW = 304;

    localparam logic [15:0] TypeIpv4  = 16'h0800;
    localparam logic [15:0] TypeDot1q = 16'h8100;
    localparam logic [7:0]  ProtoUdp  = 8'd17;

    // Byte positions within the frame.
    localparam logic [5:0] PosMacFirst   = 6'd6;
    localparam logic [5:0] PosMacLast    = 6'd11;
    localparam logic [5:0] PosKindHigh   = 6'd12;
    localparam logic [5:0] PosKindLow    = 6'd13;
    localparam logic [5:0] PosTagHigh    = 6'd14;
    localparam logic [5:0] PosTagLow     = 6'd15;
    localparam logic [5:0] PosMinLast    = 6'd13;
    localparam logic [5:0] PosMax        = 6'd63;
    localparam logic [5:0] IpAtUntagged  = 6'd14;
    localparam logic [5:0] IpAtTagged    = 6'd18;

    // Byte positions relative to the start of the IPv4 header.
    localparam logic [5:0] RelProto      = 6'd9;
    localparam logic [5:0] RelAddrFirst  = 6'd12;
    localparam logic [5:0] RelAddrLast   = 6'd19;
    localparam logic [5:0] RelPortFirst  = 6'd20;
    localparam logic [5:0] RelPortLast   = 6'd23;
    localparam logic [5:0] RelIdHigh     = 6'd32;
    localparam logic [5:0] RelIdLow      = 6'd33;

    localparam logic [31:0] NanosPerSecond = 32'd1000000000;

    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    // Input word, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]  pad;
        logic [29:0] stamp_nanos;
        logic [31:0] stamp_seconds;
        logic [7:0]  frame_byte;
    } ufsm_in_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic        pad;
        logic        sequence_gap;
        logic [15:0] feed_id;
        logic [47:0] source_mac;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] dest_address;
        logic [31:0] source_address;
        logic [15:0] vlan_tag;
        logic [29:0] gap_nanos;
        logic [31:0] gap_seconds;
        logic [31:0] ip_count;
        logic [31:0] matched_count;
    } ufsm_result_t;

    // One finished IPv4 frame handed from the parser to the match stage.
    typedef struct packed {
        logic        udp;
        logic [61:0] stamp;
        logic [15:0] tag;
        logic [47:0] mac;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic [15:0] id;
    } ufsm_rec_t;

    typedef enum logic {
        BK_IDLE,
        BK_CALC
    } ufsm_back_state_t;

    // IPv4 header offset for an Ethernet type word, zero if not handled.
    function automatic logic [5:0] ip_start(input logic [15:0] kind);
        logic [5:0] e;
        e = 6'd0;
        if (kind == TypeIpv4) begin
            e = IpAtUntagged;
        end else if (kind == TypeDot1q) begin
            e = IpAtTagged;
        end
        return e;
    endfunction

endpackage

// ===== rtl/core/udp_feed_sequence_monitor_unit.sv =====
// ============================================================================
// UDP feed sequence monitor
// Parses Ethernet/IPv4/UDP frames byte by byte and reports matching feed frames.
// ============================================================================
// Throughput: one frame byte per clock; input stalls only when the frame queue fills.
// Result path: a finished frame passes the queue entry, the work register, then the result register.
// The match stage handles each finished IPv4 frame as a difference, then an update.
// Reset: synchronous, active low; clears counters, filter, match history and queue.
// ============================================================================
module udp_feed_sequence_monitor_unit
    import ufsm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Filter register: feed id to pass, zero passes every id.
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    // Frame bytes.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,  // frame_byte[7:0], stamp_seconds[39:8],
                                          // stamp_nanos[69:40], zero[71:70]
    input  logic                s_tuser,  // frame_first
    input  logic                s_tlast,  // frame_last
    // Result words.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata   // matched_count[31:0], ip_count[63:32],
                                          // gap_seconds[95:64], gap_nanos[125:96],
                                          // vlan_tag[141:126], source_address[173:142],
                                          // dest_address[205:174], source_port[221:206],
                                          // dest_port[237:222], source_mac[285:238],
                                          // feed_id[301:286], sequence_gap[302],
                                          // zero[303]
);

    // The front parses each byte as it arrives and, on the last byte of a
    // frame that reached the IPv4 protocol byte, hands one record to the queue.
    // Frames of other types or too short never leave the front.
    logic      rec_valid;
    ufsm_rec_t rec;
    logic      q_full;

    // The back pops one record at a time, works out the time since the last
    // matching frame, applies the id filter, updates the counters and loads
    // the result register. The result register frees the back from the sink.
    ufsm_rec_t q_rec;
    logic      q_valid;
    logic      q_pop;

    ufsm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    ufsm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (rec_valid),
        .wr_data   (rec),
        .rd_en     (q_pop),
        .rd_data   (q_rec),
        .not_empty (q_valid),
        .full      (q_full)
    );

    ufsm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_rec       (q_rec),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== rtl/core/ufsm_front.sv =====
// ============================================================================
// UDP feed sequence monitor parser front
// Takes frame bytes, captures header fields and classifies finished frames.
// ============================================================================
module ufsm_front
    import ufsm_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [InDataW-1:0] s_tdata,
    input  logic            s_tuser,
    input  logic            s_tlast,
    input  logic            q_full,
    output logic            rec_valid,
    output ufsm_rec_t       rec
);

    ufsm_in_t    in_word;
    logic        accept;
    logic        active;
    logic [5:0]  pos;

    logic        open_reg,   open_next;
    logic [5:0]  offset_reg, offset_next;
    logic [15:0] kind_reg,   kind_next,   kind_cur;
    logic [15:0] tag_reg,    tag_next,    tag_cur;
    logic [7:0]  proto_reg,  proto_next,  proto_cur;
    logic [47:0] mac_reg,    mac_next,    mac_cur;
    logic [63:0] addr_reg,   addr_next,   addr_cur;
    logic [31:0] port_reg,   port_next,   port_cur;
    logic [15:0] id_reg,     id_next,     id_cur;
    logic [61:0] stamp_reg,  stamp_next;

    logic [5:0]  ip_at;
    logic [5:0]  rel;
    logic        in_ip;
    logic [5:0]  ip_end;
    logic        count_ip;
    logic        udp_ok;

    assign in_word  = ufsm_in_t'(s_tdata);
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign active   = s_tuser || open_reg;
    assign pos      = s_tuser ? 6'd0 : offset_reg;

    // A first byte starts from cleared captures.
    always_comb begin
        kind_cur   = s_tuser ? 16'd0 : kind_reg;
        tag_cur    = s_tuser ? 16'd0 : tag_reg;
        proto_cur  = s_tuser ? 8'd0  : proto_reg;
        mac_cur    = s_tuser ? 48'd0 : mac_reg;
        addr_cur   = s_tuser ? 64'd0 : addr_reg;
        port_cur   = s_tuser ? 32'd0 : port_reg;
        id_cur     = s_tuser ? 16'd0 : id_reg;
        stamp_next = s_tuser ? {in_word.stamp_seconds, in_word.stamp_nanos} : stamp_reg;
    end

    assign ip_at = ip_start(kind_cur);
    assign in_ip = (ip_at != 6'd0) && (pos >= ip_at);
    assign rel   = pos - ip_at;

    always_comb begin
        kind_next  = kind_cur;
        tag_next   = tag_cur;
        proto_next = proto_cur;
        mac_next   = mac_cur;
        addr_next  = addr_cur;
        port_next  = port_cur;
        id_next    = id_cur;
        if (pos >= PosMacFirst && pos <= PosMacLast) begin
            mac_next = {mac_cur[39:0], in_word.frame_byte};
        end
        if (pos == PosKindHigh || pos == PosKindLow) begin
            kind_next = {kind_cur[7:0], in_word.frame_byte};
        end
        if ((pos == PosTagHigh || pos == PosTagLow) && kind_cur == TypeDot1q) begin
            tag_next = {tag_cur[7:0], in_word.frame_byte};
        end
        if (in_ip) begin
            if (rel == RelProto) begin
                proto_next = in_word.frame_byte;
            end
            if (rel >= RelAddrFirst && rel <= RelAddrLast) begin
                addr_next = {addr_cur[55:0], in_word.frame_byte};
            end
            if (rel >= RelPortFirst && rel <= RelPortLast) begin
                port_next = {port_cur[23:0], in_word.frame_byte};
            end
            if (rel == RelIdHigh || rel == RelIdLow) begin
                id_next = {id_cur[7:0], in_word.frame_byte};
            end
        end
    end

    // Classification of a frame that ends on this byte.
    assign ip_end   = ip_start(kind_next);
    assign count_ip = (pos >= PosMinLast) && (ip_end != 6'd0) && (pos >= ip_end + RelProto);
    assign udp_ok   = count_ip && (proto_next == ProtoUdp) && (pos >= ip_end + RelIdLow);

    assign rec_valid = accept && active && s_tlast && count_ip;
    assign rec.udp   = udp_ok;
    assign rec.stamp = stamp_next;
    assign rec.tag   = tag_next;
    assign rec.mac   = mac_next;
    assign rec.addrs = addr_next;
    assign rec.ports = port_next;
    assign rec.id    = id_next;

    assign open_next   = !s_tlast;
    assign offset_next = (pos < PosMax) ? pos + 6'd1 : PosMax;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg   <= 1'b0;
            offset_reg <= 6'd0;
        end else if (accept && active) begin
            open_reg   <= open_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && active) begin
            kind_reg  <= kind_next;
            tag_reg   <= tag_next;
            proto_reg <= proto_next;
            mac_reg   <= mac_next;
            addr_reg  <= addr_next;
            port_reg  <= port_next;
            id_reg    <= id_next;
            stamp_reg <= stamp_next;
        end
    end

endmodule

// ===== rtl/core/ufsm_queue.sv =====
// ============================================================================
// UDP feed sequence monitor frame queue
// Short register queue of finished frames between parser and match stage.
// ============================================================================
module ufsm_queue
    import ufsm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_en,
    input  ufsm_rec_t wr_data,
    input  logic      rd_en,
    output ufsm_rec_t rd_data,
    output logic      not_empty,
    output logic      full
);

    ufsm_rec_t            entry_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueuePtrW:0]   count_reg,  count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (QueuePtrW+1)'(QueueDepth));
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = entry_reg[rd_ptr_reg];

    // Pointers wrap at the depth, which need not be a power of two.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == (QueuePtrW)'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == (QueuePtrW)'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/ufsm_back.sv =====
// ============================================================================
// UDP feed sequence monitor match stage
// Time difference, id filter, counters, sequence check and result register.
// ============================================================================
module ufsm_back
    import ufsm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                q_valid,
    input  ufsm_rec_t           q_rec,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata
);

    ufsm_back_state_t state_reg, state_next;

    ufsm_rec_t          work_reg;
    logic [31:0]        sec_diff_reg;
    logic signed [30:0] ns_diff_reg;
    logic               upd_reg;

    logic [15:0]  filter_reg;
    logic [61:0]  last_stamp_reg;
    logic [61:0]  held_reg, held_next;
    logic [15:0]  prev_id_reg;
    logic [31:0]  match_cnt_reg, match_cnt_next;
    logic [31:0]  ip_cnt_reg,    ip_cnt_next;
    logic         m_valid_reg;
    ufsm_result_t m_data_reg,    m_data_next;

    logic               emit;
    logic               out_free;
    logic               done;
    logic signed [32:0] nd;
    logic signed [32:0] nd_plus1;
    logic signed [32:0] nd_plus2;
    logic signed [32:0] nd_minus1;
    logic signed [32:0] nd_norm;
    logic [31:0]        sec_adj;
    logic               gap;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = BK_CALC;
                end
            end
            BK_CALC: begin
                if (done) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // State outputs. A frame is popped only when the previous one has fully
    // updated the match stamp it is compared against.
    always_comb begin
        q_pop = 1'b0;
        done  = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop = q_valid;
            BK_CALC: done  = !emit || out_free;
            default: begin
                q_pop = 1'b0;
                done  = 1'b0;
            end
        endcase
    end

    assign emit     = work_reg.udp && (filter_reg == 16'd0 || work_reg.id == filter_reg);
    assign out_free = !m_valid_reg || m_tready;

    // Bring the nanosecond difference into one second, borrowing from or
    // carrying into the seconds.
    assign nd        = 33'(ns_diff_reg);
    assign nd_plus1  = nd + $signed({1'b0, NanosPerSecond});
    assign nd_plus2  = nd + $signed({NanosPerSecond, 1'b0});
    assign nd_minus1 = nd - $signed({1'b0, NanosPerSecond});

    always_comb begin
        if (nd[32]) begin
            if (nd_plus1[32]) begin
                nd_norm = nd_plus2;
                sec_adj = sec_diff_reg - 32'd2;
            end else begin
                nd_norm = nd_plus1;
                sec_adj = sec_diff_reg - 32'd1;
            end
        end else if (!nd_minus1[32]) begin
            nd_norm = nd_minus1;
            sec_adj = sec_diff_reg + 32'd1;
        end else begin
            nd_norm = nd;
            sec_adj = sec_diff_reg;
        end
    end

    assign held_next      = upd_reg ? {sec_adj, nd_norm[29:0]} : held_reg;
    assign ip_cnt_next    = ip_cnt_reg + 32'd1;
    assign match_cnt_next = match_cnt_reg + 32'd1;
    assign gap = (prev_id_reg != 16'd0) &&
                 ({1'b0, work_reg.id} != ({1'b0, prev_id_reg} + 17'd1));

    always_comb begin
        m_data_next                = '0;
        m_data_next.matched_count  = match_cnt_next;
        m_data_next.ip_count       = ip_cnt_next;
        m_data_next.gap_seconds    = held_next[61:30];
        m_data_next.gap_nanos      = held_next[29:0];
        m_data_next.vlan_tag       = work_reg.tag;
        m_data_next.source_address = work_reg.addrs[63:32];
        m_data_next.dest_address   = work_reg.addrs[31:0];
        m_data_next.source_port    = work_reg.ports[31:16];
        m_data_next.dest_port      = work_reg.ports[15:0];
        m_data_next.source_mac     = work_reg.mac;
        m_data_next.feed_id        = work_reg.id;
        m_data_next.sequence_gap   = gap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            filter_reg     <= 16'd0;
            last_stamp_reg <= 62'd0;
            held_reg       <= 62'd0;
            prev_id_reg    <= 16'd0;
            match_cnt_reg  <= 32'd0;
            ip_cnt_reg     <= 32'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                filter_reg <= cfg_wr_data;
            end
            if (done) begin
                ip_cnt_reg <= ip_cnt_next;
                held_reg   <= held_next;
            end
            if (done && emit) begin
                match_cnt_reg  <= match_cnt_next;
                last_stamp_reg <= work_reg.stamp;
                prev_id_reg    <= work_reg.id;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Raw differences are taken when the frame is popped.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg     <= q_rec;
            sec_diff_reg <= q_rec.stamp[61:30] - last_stamp_reg[61:30];
            ns_diff_reg  <= $signed({1'b0, q_rec.stamp[29:0]})
                          - $signed({1'b0, last_stamp_reg[29:0]});
            upd_reg      <= q_rec.udp && (last_stamp_reg != 62'd0);
        end
        if (done && emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OutDataW'(m_data_reg);

endmodule

// ===== rtl/core/ufsm_checker.sv =====
// ============================================================================
// UDP feed sequence monitor port checker
// Watches the top level ports and checks result ordering and ranges.
// ============================================================================
`include "udp_feed_sequence_monitor_unit_defines.svh"

module ufsm_checker
    import ufsm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OutDataW-1:0] m_tdata
);

    ufsm_result_t res;
    logic         out_take;
    logic         seen_reg;
    logic [31:0]  last_matched_reg;
    logic [31:0]  last_ip_reg;

    assign res      = ufsm_result_t'(m_tdata);
    assign out_take = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg         <= 1'b0;
            last_matched_reg <= 32'd0;
            last_ip_reg      <= 32'd0;
        end else if (out_take) begin
            seen_reg         <= 1'b1;
            last_matched_reg <= res.matched_count;
            last_ip_reg      <= res.ip_count;
        end
    end

    // A stalled result word stays put.
    `UFSM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The reported nanosecond gap is always normalized.
    `UFSM_ASSERT_IMPL(a_gap_nanos_range, m_tvalid, res.gap_nanos < NanosPerSecond[29:0])

    // Each delivered result is exactly one match after the previous one.
    `UFSM_ASSERT_IMPL(a_match_step, out_take && seen_reg, res.matched_count == last_matched_reg + 32'd1)

    // Each result comes from a new IPv4 frame, so the frame count moves.
    `UFSM_ASSERT_IMPL(a_ip_advance, out_take && seen_reg, res.ip_count != last_ip_reg)

endmodule

bind udp_feed_sequence_monitor_unit ufsm_checker u_ufsm_checker (.*);

// ===== sim/tb_udp_feed_sequence_monitor_unit.sv =====
// ============================================================================
// UDP feed sequence monitor testbench
// Feeds Ethernet frames one byte per word and checks every result word
// against a built-in frame tracker: directed frames first, then random traffic.
// ============================================================================
module tb_udp_feed_sequence_monitor_unit;
    import ufsm_pkg::*;

    localparam longint NsPerSec = 1_000_000_000;

    // Every block input holds a known value from time zero.
    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [15:0]         cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata     = '0;  // frame_byte, stamp_seconds, stamp_nanos, zero
    logic                s_tuser     = 1'b0; // frame_first
    logic                s_tlast     = 1'b0; // frame_last
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [OutDataW-1:0] m_tdata;

    udp_feed_sequence_monitor_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Frame tracker state. It mirrors what the block must remember: the byte
    // position, the fields captured so far in the open frame, and the history
    // of matching frames (last stamp, last id, held difference, counters).
    // ------------------------------------------------------------------------
    logic [15:0] filt;
    int          at_pos;
    bit          in_frame;
    logic [15:0] kind_word;
    logic [15:0] vlan_word;
    logic [7:0]  proto;
    logic [47:0] mac_acc;
    logic [63:0] addr_acc;
    logic [31:0] port_acc;
    logic [15:0] id_acc;
    logic [61:0] stamp_now;
    logic [61:0] stamp_last;
    logic [61:0] delta_held;
    logic [15:0] last_id;
    logic [31:0] n_match;
    logic [31:0] n_ip;

    // Result words the block owes us, oldest first.
    ufsm_result_t feed_reports[$];

    // Stimulus bookkeeping.
    logic [7:0]  frame_bytes[$];
    logic [31:0] now_sec;
    longint      now_ns;
    logic [15:0] id_seq;
    int          bytes_sent;
    int          errors;

    // Idling control. While calm is set neither side inserts random gaps;
    // hold_request asks the receiver for one long stall.
    bit calm;
    int hold_request;
    int hold_left;
    int stall_left;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Generous fixed limit; a correct run finishes far earlier.
    initial begin
        #400_000;
        $display("simulation failed");
        $finish;
    end

    // Offset of the IPv4 header for an Ethernet type word, zero if unhandled.
    function automatic int ipv4_offset(input logic [15:0] kind);
        if (kind == TypeIpv4) return IpAtUntagged;
        if (kind == TypeDot1q) return IpAtTagged;
        return 0;
    endfunction

    // Difference of two stamps. The nanosecond part is brought back into
    // range by borrowing from or carrying into the seconds; inputs of a
    // billion nanoseconds or more are legal, hence two borrow steps.
    function automatic logic [61:0] stamp_gap(input logic [61:0] later,
                                              input logic [61:0] earlier);
        logic [31:0] s;
        longint      d;
        s = later[61:30] - earlier[61:30];
        d = longint'({34'd0, later[29:0]}) - longint'({34'd0, earlier[29:0]});
        if (d < 0) begin
            d += NsPerSec;
            s -= 32'd1;
        end
        if (d < 0) begin
            d += NsPerSec;
            s -= 32'd1;
        end
        if (d >= NsPerSec) begin
            d -= NsPerSec;
            s += 32'd1;
        end
        return {s, d[29:0]};
    endfunction

    function automatic void reset_tracker();
        filt = '0;
        at_pos = 0;
        in_frame = 1'b0;
        kind_word = '0;
        vlan_word = '0;
        proto = '0;
        mac_acc = '0;
        addr_acc = '0;
        port_acc = '0;
        id_acc = '0;
        stamp_now = '0;
        stamp_last = '0;
        delta_held = '0;
        last_id = '0;
        n_match = '0;
        n_ip = '0;
    endfunction

    // Frame end: decide whether the frame counts as IPv4, whether it is a UDP
    // frame long enough to carry the feed id, and whether the id passes.
    function automatic void close_frame(input int pos);
        int           e;
        bit           gap;
        ufsm_result_t rep;
        e = ipv4_offset(kind_word);
        // Too short for a type word, unknown type, or cut before the protocol.
        if (pos < PosMinLast || e == 0 || pos < e + RelProto) return;
        n_ip += 32'd1;
        if (proto != ProtoUdp || pos < e + RelIdLow) return;
        // The time difference moves on every long UDP frame, filtered or not.
        if (stamp_last != '0) delta_held = stamp_gap(stamp_now, stamp_last);
        if (filt != '0 && id_acc != filt) return;
        n_match += 32'd1;
        stamp_last = stamp_now;
        gap = last_id != '0 && {16'd0, id_acc} != {16'd0, last_id} + 32'd1;
        last_id = id_acc;
        rep = '0;
        rep.matched_count  = n_match;
        rep.ip_count       = n_ip;
        rep.gap_seconds    = delta_held[61:30];
        rep.gap_nanos      = delta_held[29:0];
        rep.vlan_tag       = vlan_word;
        rep.source_address = addr_acc[63:32];
        rep.dest_address   = addr_acc[31:0];
        rep.source_port    = port_acc[31:16];
        rep.dest_port      = port_acc[15:0];
        rep.source_mac     = mac_acc;
        rep.feed_id        = id_acc;
        rep.sequence_gap   = gap;
        feed_reports.push_back(rep);
    endfunction

    // One accepted frame byte.
    function automatic void track_frame_byte(input logic [7:0] b, input bit first,
                                             input bit last, input logic [31:0] sec,
                                             input logic [29:0] ns);
        int pos;
        int e;
        int r;
        if (first) begin
            // A new first byte also abandons any frame still open.
            in_frame = 1'b1;
            pos = 0;
            kind_word = '0;
            vlan_word = '0;
            proto = '0;
            mac_acc = '0;
            addr_acc = '0;
            port_acc = '0;
            id_acc = '0;
            stamp_now = {sec, ns};
        end else if (!in_frame) begin
            return;
        end else begin
            pos = at_pos;
        end
        if (pos >= PosMacFirst && pos <= PosMacLast) mac_acc = {mac_acc[39:0], b};
        if (pos == PosKindHigh || pos == PosKindLow) kind_word = {kind_word[7:0], b};
        if (pos >= PosTagHigh) begin
            if ((pos == PosTagHigh || pos == PosTagLow) && kind_word == TypeDot1q)
                vlan_word = {vlan_word[7:0], b};
            e = ipv4_offset(kind_word);
            if (e != 0 && pos >= e) begin
                r = pos - e;
                if (r == RelProto) proto = b;
                if (r >= RelAddrFirst && r <= RelAddrLast) addr_acc = {addr_acc[55:0], b};
                if (r >= RelPortFirst && r <= RelPortLast) port_acc = {port_acc[23:0], b};
                if (r == RelIdHigh || r == RelIdLow) id_acc = {id_acc[7:0], b};
            end
        end
        at_pos = pos < PosMax ? pos + 1 : PosMax;
        if (!last) return;
        in_frame = 1'b0;
        close_frame(pos);
    endfunction

    // ------------------------------------------------------------------------
    // Result side. The receiver takes a word whenever valid and ready meet at
    // an edge, compares it with the oldest expected word, then decides ready
    // for the next cycle: a long hold if one was asked for, else short random
    // stall bursts unless calm is set.
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_report(input ufsm_result_t got);
        ufsm_result_t want;
        if (feed_reports.size() == 0) begin
            $error("result word with none expected: matched_count %0d", got.matched_count);
            errors++;
            return;
        end
        want = feed_reports.pop_front();
        compare_field("matched_count", want.matched_count, got.matched_count);
        compare_field("ip_count", want.ip_count, got.ip_count);
        compare_field("gap_seconds", want.gap_seconds, got.gap_seconds);
        compare_field("gap_nanos", want.gap_nanos, got.gap_nanos);
        compare_field("vlan_tag", want.vlan_tag, got.vlan_tag);
        compare_field("source_address", want.source_address, got.source_address);
        compare_field("dest_address", want.dest_address, got.dest_address);
        compare_field("source_port", want.source_port, got.source_port);
        compare_field("dest_port", want.dest_port, got.dest_port);
        compare_field("source_mac", want.source_mac, got.source_mac);
        compare_field("feed_id", want.feed_id, got.feed_id);
        compare_field("sequence_gap", want.sequence_gap, got.sequence_gap);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_report(m_tdata);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Words are driven at a rising edge and held until the block
    // takes them; valid is lowered only for a random gap or a drain, never lowered and
    // raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] data_byte, input bit first, input bit last,
                             input logic [31:0] sec, input logic [29:0] ns);
        ufsm_in_t w;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        w = '0;
        w.frame_byte = data_byte;
        w.stamp_seconds = sec;
        w.stamp_nanos = ns;
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= first;
        s_tlast <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        track_frame_byte(data_byte, first, last, sec, ns);
        bytes_sent++;
    endtask

    // Sends frame_bytes. Only the first word carries the real stamp; the
    // others carry noise that the block must ignore. An unclosed frame has
    // no last mark on its final byte.
    task automatic send_frame(input bit closed);
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_word(frame_bytes[i], i == 0, closed && i == n - 1,
                      i == 0 ? now_sec : $urandom,
                      i == 0 ? 30'(now_ns) : 30'($urandom));
        end
    endtask

    // Fills frame_bytes with len bytes of the given fill (random if negative)
    // and places the type word, protocol and feed id where they belong.
    task automatic build_frame(input logic [15:0] kind, input logic [7:0] prot,
                               input logic [15:0] id, input int len, input int fill);
        int e;
        frame_bytes.delete();
        for (int i = 0; i < len; i++)
            frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        e = ipv4_offset(kind);
        if (len > PosKindHigh) frame_bytes[PosKindHigh] = kind[15:8];
        if (len > PosKindLow) frame_bytes[PosKindLow] = kind[7:0];
        if (e != 0) begin
            if (len > e + RelProto) frame_bytes[e + RelProto] = prot;
            if (len > e + RelIdHigh) frame_bytes[e + RelIdHigh] = id[15:8];
            if (len > e + RelIdLow) frame_bytes[e + RelIdLow] = id[7:0];
        end
    endtask

    // Shortest frame that still carries the whole feed id.
    function automatic int full_length(input logic [15:0] kind);
        return ipv4_offset(kind) + RelIdLow + 1;
    endfunction

    task automatic send_udp(input logic [15:0] kind, input logic [15:0] id, input int fill,
                            input logic [31:0] sec, input longint ns);
        now_sec = sec;
        now_ns = ns;
        build_frame(kind, ProtoUdp, id, full_length(kind), fill);
        send_frame(1'b1);
    endtask

    // Stops offering words and waits until every expected result has come,
    // then a little longer so that frames without a result leave the block.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (feed_reports.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_filter(input logic [15:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        filt = value;
    endtask

    // Capture time moves forward by up to a few seconds, with the odd jump
    // backward, an arbitrary raw value, or the all-zero stamp.
    task automatic advance_clock();
        int unsigned r;
        r = $urandom_range(0, 39);
        if (r == 0) begin
            now_sec = '0;
            now_ns = 0;
        end else if (r < 5) begin
            now_sec = $urandom;
            now_ns = $urandom_range(0, 30'h3FFF_FFFF);
        end else begin
            now_ns += $urandom_range(0, 999_999_999);
            now_sec += $urandom_range(0, 2);
            if (r < 8) now_sec -= $urandom_range(1, 3);
            while (now_ns >= NsPerSec) begin
                now_ns -= NsPerSec;
                now_sec += 32'd1;
            end
        end
    endtask

    // Mostly a running sequence, with the filter value favored when one is
    // set, and some restarts, wraps and jumps so that gaps appear.
    function automatic logic [15:0] pick_feed_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (filt != '0 && r < 60) return filt;
        if (r < 80) id_seq += 16'd1;
        else if (r < 86) id_seq = '0;
        else if (r < 91) id_seq = 16'hFFFF;
        else id_seq = 16'($urandom);
        return id_seq;
    endfunction

    // Most random frames are well formed matching candidates; the rest are
    // other protocols, unknown types, truncated or abandoned frames and
    // stray bytes outside any frame.
    task automatic send_random_frame();
        int unsigned r;
        int          e;
        logic [15:0] kind;
        r = $urandom_range(0, 99);
        kind = $urandom_range(0, 1) ? TypeIpv4 : TypeDot1q;
        e = ipv4_offset(kind);
        advance_clock();
        if (r < 70) begin
            build_frame(kind, ProtoUdp, pick_feed_id(), full_length(kind) +
                        ($urandom_range(0, 3) == 0 ? $urandom_range(0, 40)
                                                   : $urandom_range(0, 4)), -1);
            send_frame(1'b1);
        end else if (r < 78) begin
            build_frame(kind, 8'($urandom), 16'($urandom), $urandom_range(e + RelProto, 60),
                        -1);
            send_frame(1'b1);
        end else if (r < 84) begin
            build_frame(16'($urandom), ProtoUdp, 16'($urandom), $urandom_range(1, 60), -1);
            send_frame(1'b1);
        end else if (r < 90) begin
            build_frame(kind, ProtoUdp, pick_feed_id(), $urandom_range(1, e + RelIdLow), -1);
            send_frame(1'b1);
        end else if (r < 95) begin
            build_frame(kind, ProtoUdp, pick_feed_id(), $urandom_range(1, full_length(kind)), -1);
            send_frame(1'b0);
        end else begin
            repeat ($urandom_range(1, 4))
                send_word(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), $urandom,
                          30'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes with the filter at its reset value. The first match is
    // stamped zero, which counts as no match, so the next difference stays
    // zero; ids step through a wrap from all ones to zero.
    task automatic test_field_extremes();
        send_udp(TypeIpv4, 16'hFFFF, 8'hFF, 32'd0, 0);
        send_udp(TypeDot1q, 16'h0000, 8'h00, 32'hFFFF_FFFF, 999_999_999);
        send_udp(TypeDot1q, 16'h0001, 8'hFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
        send_udp(TypeIpv4, 16'h0002, -1, 32'h0000_0001, 17);
        send_udp(TypeIpv4, 16'h0007, -1, 32'h0000_0002, 5);
    endtask

    // Frames that count as IPv4 but carry no UDP, and frames of other types.
    task automatic test_other_frames();
        now_sec = 32'd100;
        now_ns = 0;
        build_frame(TypeIpv4, 8'd6, 16'h0008, full_length(TypeIpv4), -1);
        send_frame(1'b1);
        build_frame(TypeDot1q, 8'hFF, 16'h0008, full_length(TypeDot1q), -1);
        send_frame(1'b1);
        build_frame(16'h86DD, ProtoUdp, 16'h0008, 30, -1);
        send_frame(1'b1);
        build_frame(16'h0000, ProtoUdp, 16'h0008, 20, -1);
        send_frame(1'b1);
        build_frame(16'hFFFF, ProtoUdp, 16'h0008, 20, -1);
        send_frame(1'b1);
        send_udp(TypeIpv4, 16'h0008, -1, 32'd101, 250);
    endtask

    // Length edges of a UDP frame: before the type word, one byte into it, ending on
    // its last byte, one short of the protocol byte, at the protocol byte, one short
    // of the second id byte, exactly complete, and well past the last looked-at byte.
    task automatic test_short_frames();
        int lens[6];
        lens = '{6, 13, 14, 23, 24, 47};
        foreach (lens[i]) begin
            build_frame(TypeIpv4, ProtoUdp, 16'h0009, lens[i], -1);
            send_frame(1'b1);
        end
        build_frame(TypeDot1q, ProtoUdp, 16'h000A, full_length(TypeDot1q) - 1, -1);
        send_frame(1'b1);
        send_udp(TypeIpv4, 16'h000A, -1, 32'd102, 0);
        build_frame(TypeDot1q, ProtoUdp, 16'h000B, 90, -1);
        send_frame(1'b1);
    endtask

    // Bytes outside a frame, a frame of one byte, and a frame abandoned by a
    // new first byte.
    task automatic test_framing_errors();
        send_word(8'hA5, 1'b0, 1'b1, $urandom, 30'($urandom));
        send_word(8'h5A, 1'b0, 1'b0, $urandom, 30'($urandom));
        send_word(8'h11, 1'b1, 1'b1, $urandom, 30'($urandom));
        build_frame(TypeIpv4, ProtoUdp, 16'h00C0, 40, -1);
        send_frame(1'b0);
        send_udp(TypeDot1q, 16'h000C, -1, 32'd103, 1);
    endtask

    // Differences that need a borrow, a carry from an oversized nanosecond
    // input, a seconds wrap, and a stamp that moves backward.
    task automatic test_stamp_arithmetic();
        send_udp(TypeIpv4, 16'h0010, -1, 32'd10, 999_999_999);
        send_udp(TypeIpv4, 16'h0011, -1, 32'd11, 0);
        send_udp(TypeIpv4, 16'h0012, -1, 32'd11, 30'h3FFF_FFFF);
        send_udp(TypeIpv4, 16'h0013, -1, 32'hFFFF_FFFF, 5);
        send_udp(TypeIpv4, 16'h0014, -1, 32'd0, 3);
        send_udp(TypeIpv4, 16'h0015, -1, 32'd0, 2);
    endtask

    // Filter at its top value and at one; a filtered-out frame still moves
    // the held difference seen by the next match.
    task automatic test_filter_values();
        write_filter(16'hFFFF);
        send_udp(TypeIpv4, 16'hFFFF, -1, 32'd200, 0);
        send_udp(TypeDot1q, 16'h1234, -1, 32'd201, 500);
        send_udp(TypeIpv4, 16'hFFFF, -1, 32'd203, 7);
        write_filter(16'h0001);
        send_udp(TypeIpv4, 16'h0001, -1, 32'd204, 0);
        send_udp(TypeIpv4, 16'h0002, -1, 32'd205, 0);
        send_udp(TypeDot1q, 16'h0001, -1, 32'd206, 0);
        write_filter(16'h0000);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering matching frames back to back, so the block has to fill up
    // and stall its input.
    task automatic test_output_backpressure();
        drain();
        calm = 1'b1;
        hold_request = 400;
        repeat (6) begin
            now_ns += 1000;
            id_seq += 16'd1;
            send_udp(TypeIpv4, id_seq, -1, now_sec, now_ns);
        end
        drain();
        calm = 1'b0;
    endtask

    // Random traffic under one filter setting, until the byte budget is spent.
    task automatic test_random_traffic(input logic [15:0] filter, input int byte_budget,
                                       input bit quiet);
        int bytes_start;
        write_filter(filter);
        bytes_start = bytes_sent;
        while (bytes_sent - bytes_start < byte_budget) begin
            calm = quiet || $urandom_range(0, 4) == 0;
            send_random_frame();
        end
        calm = quiet;
    endtask

    initial begin
        reset_tracker();
        now_sec = '0;
        now_ns = 0;
        id_seq = '0;
        bytes_sent = 0;
        errors = 0;
        calm = 1'b0;
        hold_request = 0;
        hold_left = 0;
        stall_left = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_other_frames();
        test_short_frames();
        test_framing_errors();
        test_stamp_arithmetic();
        test_filter_values();
        test_output_backpressure();
        test_random_traffic(16'h0000, 80, 1'b0);
        test_random_traffic(16'($urandom_range(2, 16'hFFFE)), 40, 1'b0);
        test_random_traffic(16'hFFFF, 40, 1'b0);
        // The closing stretch runs with no idling on either side.
        test_random_traffic(16'h0000, 100, 1'b1);
        drain();

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
